// ----- src/apu_pkg.sv -----
// Package for the average-predictor unfilter: sizes, register indexes and the
// pixel and stage types shared by the sequencer and the reconstruction stage.
// No dependencies.
package apu_pkg;

  // Line buffer depth, the widest row the block can rebuild.
  localparam int unsigned MaxWidth = 4096;
  // Column index width, enough to address every line buffer entry.
  localparam int unsigned ColW = $clog2(MaxWidth);

  // Configuration register widths and port sizes.
  localparam int unsigned WidthRegW  = 13;
  localparam int unsigned HeightRegW = 16;
  localparam int unsigned CfgDataW   = 16;
  localparam int unsigned CfgIdxW    = 2;

  // Compare width for column arithmetic: holds the width register, MaxWidth and col + 1.
  localparam int unsigned CmpW = ((ColW > WidthRegW) ? ColW : WidthRegW) + 1;
  // Compare width for row arithmetic: holds row + 1 without wrapping.
  localparam int unsigned RowCmpW = HeightRegW + 1;

  localparam int unsigned NumChan = 4;
  localparam int unsigned ChanW   = 8;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CfgImageWidth   = 2'd0,
    CfgImageHeight  = 2'd1,
    CfgFourChannels = 2'd2
  } cfg_idx_e;

  typedef logic [ChanW-1:0] chan_t;
  typedef chan_t [NumChan-1:0] pixel_t;

  // One issued pixel: its line buffer column, position flags and residuals.
  typedef struct packed {
    logic [ColW-1:0] col;
    logic            first_row;
    logic            first_col;
    logic            image_end;
    pixel_t          resid;
  } issue_t;

endpackage

// ----- src/apu_stream_if.sv -----
// Stream interfaces for residual pixels in and rebuilt pixels out.
// Depends on apu_pkg for the channel byte width.
interface apu_in_if;
  logic                 valid;
  logic                 ready;
  logic [apu_pkg::ChanW-1:0] resid_0;
  logic [apu_pkg::ChanW-1:0] resid_1;
  logic [apu_pkg::ChanW-1:0] resid_2;
  logic [apu_pkg::ChanW-1:0] resid_3;

  modport source (output valid, output resid_0, output resid_1, output resid_2,
                  output resid_3, input ready);
  modport sink (input valid, input resid_0, input resid_1, input resid_2,
                input resid_3, output ready);
endinterface

interface apu_out_if;
  logic                 valid;
  logic                 ready;
  logic [apu_pkg::ChanW-1:0] pix_0;
  logic [apu_pkg::ChanW-1:0] pix_1;
  logic [apu_pkg::ChanW-1:0] pix_2;
  logic [apu_pkg::ChanW-1:0] pix_3;
  logic                 image_end;

  modport source (output valid, output pix_0, output pix_1, output pix_2,
                  output pix_3, output image_end, input ready);
  modport sink (input valid, input pix_0, input pix_1, input pix_2,
                input pix_3, input image_end, output ready);
endinterface

// ----- src/average_predictor_unfilter.sv -----
// Average-predictor unfilter: rebuilds raster-order pixels from residuals at one
// pixel per clock while the output is not stalled; each transfer passes a stage and an output register.
// Each pixel takes one line buffer read (the pixel above) and one write (itself);
// the single read and single write port of that memory set the rate. The
// image_end flag marks the last pixel, after which the next transfer starts a
// new image. Write the size and channel registers only while the block is idle.
// The line buffer has no clearing pass and no reset. Depends on apu_pkg,
// apu_in_if, apu_out_if, apu_seq and apu_recon.
module average_predictor_unfilter (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [apu_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [apu_pkg::CfgDataW-1:0] cfg_wdata_i,
  apu_in_if.sink                       pix_in,
  apu_out_if.source                    pix_out
);

  logic            take;
  logic            free;
  logic            four_ch;
  apu_pkg::pixel_t resid;
  apu_pkg::pixel_t pix;
  apu_pkg::issue_t issue;

  // An input transfer needs room in the reconstruction stage.
  assign pix_in.ready = free;
  assign take         = pix_in.valid && free;

  assign resid = {pix_in.resid_3, pix_in.resid_2, pix_in.resid_1, pix_in.resid_0};

  apu_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .take_i      (take),
    .resid_i     (resid),
    .issue_o     (issue),
    .four_ch_o   (four_ch)
  );

  apu_recon u_recon (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .issue_i     (issue),
    .four_ch_i   (four_ch),
    .free_o      (free),
    .out_valid_o (pix_out.valid),
    .out_ready_i (pix_out.ready),
    .pix_o       (pix),
    .image_end_o (pix_out.image_end)
  );

  assign pix_out.pix_0 = pix[0];
  assign pix_out.pix_1 = pix[1];
  assign pix_out.pix_2 = pix[2];
  assign pix_out.pix_3 = pix[3];

endmodule

// ----- src/apu_seq.sv -----
// Sequencer: configuration registers and the raster column and row counters.
// Issues each accepted pixel with its column and position flags. Uses apu_pkg.
module apu_seq (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [apu_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [apu_pkg::CfgDataW-1:0]  cfg_wdata_i,
  input  logic                          take_i,
  input  apu_pkg::pixel_t               resid_i,
  output apu_pkg::issue_t               issue_o,
  output logic                          four_ch_o
);

  logic [apu_pkg::WidthRegW-1:0]  width_q;
  logic [apu_pkg::HeightRegW-1:0] height_q;
  logic                           four_q;
  logic [apu_pkg::ColW-1:0]       col_q, col_d;
  logic [apu_pkg::HeightRegW-1:0] row_q, row_d;

  logic [apu_pkg::CmpW-1:0]    w_eff, col_ext;
  logic [apu_pkg::RowCmpW-1:0] h_eff, row_ext;
  logic                        last_col, last_row;

  // Effective sizes: zero counts as one, and the width saturates at the buffer depth.
  always_comb begin
    w_eff = apu_pkg::CmpW'(width_q);
    if (w_eff == '0) begin
      w_eff = apu_pkg::CmpW'(1);
    end else if (w_eff > apu_pkg::CmpW'(apu_pkg::MaxWidth)) begin
      w_eff = apu_pkg::CmpW'(apu_pkg::MaxWidth);
    end
    h_eff = apu_pkg::RowCmpW'(height_q);
    if (h_eff == '0) begin
      h_eff = apu_pkg::RowCmpW'(1);
    end
  end

  // Clamp the column to the last one in case the width shrank mid-image.
  always_comb begin
    col_ext = apu_pkg::CmpW'(col_q);
    if (col_ext >= w_eff) begin
      col_ext = w_eff - apu_pkg::CmpW'(1);
    end
    row_ext  = apu_pkg::RowCmpW'(row_q);
    last_col = (col_ext + apu_pkg::CmpW'(1)) >= w_eff;
    last_row = (row_ext + apu_pkg::RowCmpW'(1)) >= h_eff;
  end

  always_comb begin
    issue_o.col       = col_ext[apu_pkg::ColW-1:0];
    issue_o.first_row = (row_q == '0);
    issue_o.first_col = (col_ext == '0);
    issue_o.image_end = last_col && last_row;
    issue_o.resid     = resid_i;
    four_ch_o         = four_q;
  end

  // Counter advance on every transfer; both wrap to zero after the last pixel.
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (take_i) begin
      if (last_col) begin
        col_d = '0;
        row_d = last_row ? '0 : row_q + apu_pkg::HeightRegW'(1);
      end else begin
        col_d = col_ext[apu_pkg::ColW-1:0] + apu_pkg::ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= apu_pkg::WidthRegW'(1);
      height_q <= apu_pkg::HeightRegW'(1);
      four_q   <= 1'b0;
      col_q    <= '0;
      row_q    <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      if (cfg_we_i) begin
        case (apu_pkg::cfg_idx_e'(cfg_idx_i))
          apu_pkg::CfgImageWidth:   width_q  <= cfg_wdata_i[apu_pkg::WidthRegW-1:0];
          apu_pkg::CfgImageHeight:  height_q <= cfg_wdata_i[apu_pkg::HeightRegW-1:0];
          apu_pkg::CfgFourChannels: four_q   <= cfg_wdata_i[0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ----- src/apu_recon.sv -----
// Reconstruction stage: line buffer memory, predictor and output register.
// Reads the pixel above at issue into a register, then rebuilds the pixel from the stage register. Uses apu_pkg.
module apu_recon (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            take_i,
  input  apu_pkg::issue_t issue_i,
  input  logic            four_ch_i,
  output logic            free_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output apu_pkg::pixel_t pix_o,
  output logic            image_end_o
);

  // Previous row, one pixel per entry.
  apu_pkg::pixel_t line_mem_q [apu_pkg::MaxWidth];
  apu_pkg::pixel_t rd_q;

  logic            s1_valid_q;
  apu_pkg::issue_t s1_q;
  logic            fwd_q;
  apu_pkg::pixel_t left_q;
  apu_pkg::pixel_t px, up;
  logic            out_valid_q;
  apu_pkg::pixel_t out_pix_q;
  logic            out_end_q;
  logic            s1_fire;
  logic [apu_pkg::ChanW:0] sum;

  assign s1_fire = s1_valid_q && (!out_valid_q || out_ready_i);
  assign free_o  = !s1_valid_q || s1_fire;

  // Line buffer: the write of the rebuilt pixel and the read for the next transfer.
  always_ff @(posedge clk_i) begin
    if (s1_fire) begin
      line_mem_q[s1_q.col] <= px;
    end
    if (take_i) begin
      rd_q <= line_mem_q[issue_i.col];
    end
  end

  // When the read hits the entry being written (one-pixel-wide rows), the pixel
  // above is the one just rebuilt, which is the left pixel register.
  assign up = fwd_q ? left_q : rd_q;

  // Per-channel prediction and wrapping add; alpha is zero in three-channel mode.
  always_comb begin
    px  = '0;
    sum = '0;
    for (int c = 0; c < apu_pkg::NumChan; c++) begin
      if (s1_q.first_row && s1_q.first_col) begin
        sum = '0;
      end else if (s1_q.first_row) begin
        sum = {1'b0, left_q[c]};
      end else if (s1_q.first_col) begin
        sum = {1'b0, up[c]};
      end else begin
        sum = ({1'b0, left_q[c]} + {1'b0, up[c]}) >> 1;
      end
      px[c] = s1_q.resid[c] + sum[apu_pkg::ChanW-1:0];
    end
    if (!four_ch_i) begin
      px[apu_pkg::NumChan-1] = '0;
    end
  end

  // Stage and output register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      fwd_q       <= 1'b0;
      left_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (take_i) begin
        s1_valid_q <= 1'b1;
        fwd_q      <= s1_fire && (s1_q.col == issue_i.col);
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_fire) begin
        left_q      <= px;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (take_i) begin
      s1_q <= issue_i;
    end
    if (s1_fire) begin
      out_pix_q <= px;
      out_end_q <= s1_q.image_end;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pix_o       = out_pix_q;
  assign image_end_o = out_end_q;

endmodule
